// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the controller RTL.
// Needs signals clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that a property holds on every clock out of reset
`define PS2KMC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that a condition never holds out of reset
`define PS2KMC_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/ps2kmc_pkg.sv =====
// Types, codes and constants of the keyboard and mouse controller.
// No dependencies.
`default_nettype none

package ps2kmc_pkg;

	localparam logic [2:0] MODE_BUS_READ  = 3'd0;
	localparam logic [2:0] MODE_BUS_WRITE = 3'd1;
	localparam logic [2:0] MODE_KEY       = 3'd2;
	localparam logic [2:0] MODE_MOVE      = 3'd3;
	localparam logic [2:0] MODE_BUTTON    = 3'd4;
	localparam logic [2:0] MODE_REPORT    = 3'd5;

	localparam logic [2:0] OFF_DATA  = 3'd0;
	localparam logic [2:0] OFF_PORTB = 3'd1;
	localparam logic [2:0] OFF_CMD   = 3'd4;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_UNSUP   = 3'd1;
	localparam logic [2:0] ERR_OVERLAP = 3'd2;
	localparam logic [2:0] ERR_DEVCMD  = 3'd3;
	localparam logic [2:0] ERR_FIFO    = 3'd4;
	localparam logic [2:0] ERR_RANGE   = 3'd5;

	localparam logic [1:0] DEST_KBD   = 2'd0;
	localparam logic [1:0] DEST_MOUSE = 2'd1;
	localparam logic [1:0] DEST_RAM   = 2'd2;
	localparam logic [1:0] DEST_OUTP  = 2'd3;

	localparam logic [1:0] SRC_EMPTY = 2'd0;
	localparam logic [1:0] SRC_KBD   = 2'd1;
	localparam logic [1:0] SRC_MOUSE = 2'd2;

	localparam logic [7:0] BYTE_ACK     = 8'hFA;
	localparam logic [7:0] BYTE_TEST_OK = 8'h55;
	localparam logic [7:0] BYTE_BAT_OK  = 8'hAA;
	localparam logic [7:0] BYTE_EXT     = 8'hE0;
	localparam logic [7:0] BYTE_ZERO    = 8'h00;
	localparam logic [7:0] A20_OFF      = 8'hDD;
	localparam logic [7:0] A20_ON       = 8'hDF;
	localparam logic [7:0] RAM_CFG_ADDR  = 8'h20;
	localparam logic [7:0] RAM_BASE_ADDR = 8'h2B;
	localparam logic [7:0] TARGET_NONE   = 8'hFF;
	localparam logic [7:0] CFG_RESET     = 8'h20;
	localparam logic [7:0] BASE_RESET    = 8'h20;
	localparam logic [7:0] RATE_RESET    = 8'd100;
	localparam logic [7:0] RES_RESET     = 8'd2;

	localparam int CFG_KBD_IRQ = 0;
	localparam int CFG_MS_IRQ  = 1;
	localparam int CFG_KBD_DIS = 4;
	localparam int CFG_MS_DIS  = 5;

	localparam logic [7:0] CMD_MS_DISABLE  = 8'hA7;
	localparam logic [7:0] CMD_MS_ENABLE   = 8'hA8;
	localparam logic [7:0] CMD_MS_TEST     = 8'hA9;
	localparam logic [7:0] CMD_SELF_TEST   = 8'hAA;
	localparam logic [7:0] CMD_KBD_TEST    = 8'hAB;
	localparam logic [7:0] CMD_KBD_DISABLE = 8'hAD;
	localparam logic [7:0] CMD_KBD_ENABLE  = 8'hAE;
	localparam logic [7:0] CMD_WR_OUTPORT  = 8'hD1;
	localparam logic [7:0] CMD_WR_MOUSE    = 8'hD4;
	localparam logic [7:0] CMD_NOP         = 8'hFF;

	localparam logic [7:0] KB_CMD_MISC    = 8'h05;
	localparam logic [7:0] KB_CMD_LEDS    = 8'hED;
	localparam logic [7:0] KB_CMD_ID      = 8'hF2;
	localparam logic [7:0] KB_CMD_RATE    = 8'hF3;
	localparam logic [7:0] KB_CMD_ENABLE  = 8'hF4;
	localparam logic [7:0] KB_CMD_DISABLE = 8'hF5;
	localparam logic [7:0] KB_CMD_RESET   = 8'hFF;

	localparam logic [7:0] MS_CMD_SCALE1   = 8'hE6;
	localparam logic [7:0] MS_CMD_SCALE2   = 8'hE7;
	localparam logic [7:0] MS_CMD_SET_RES  = 8'hE8;
	localparam logic [7:0] MS_CMD_STATUS   = 8'hE9;
	localparam logic [7:0] MS_CMD_END_WRAP = 8'hEC;
	localparam logic [7:0] MS_CMD_WRAP     = 8'hEE;
	localparam logic [7:0] MS_CMD_ID       = 8'hF2;
	localparam logic [7:0] MS_CMD_RATE     = 8'hF3;
	localparam logic [7:0] MS_CMD_ENABLE   = 8'hF4;
	localparam logic [7:0] MS_CMD_DISABLE  = 8'hF5;
	localparam logic [7:0] MS_CMD_RESET    = 8'hFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RAMRD,
		ST_PUSH,
		ST_FILL,
		ST_LOAD,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic       we;
		logic       clr;
		logic [7:0] waddr;
		logic [7:0] wdata;
		logic [7:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic       push;
		logic       pop;
		logic       clr;
		logic [7:0] wdata;
	} fifo_req_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_sts_t;

	function automatic logic [7:0] ram_init_byte(logic [7:0] addr);
		if (addr == RAM_CFG_ADDR) return CFG_RESET;
		if (addr == RAM_BASE_ADDR) return BASE_RESET;
		return 8'h00;
	endfunction

	function automatic logic [15:0] sat16(logic [16:0] s);
		if (s[16] != s[15]) return s[16] ? 16'h8000 : 16'h7FFF;
		return s[15:0];
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ps2kmc_if.sv =====
// Request and response channel interfaces of the controller.
// No dependencies.
`default_nettype none

interface ps2kmc_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         mode;
	logic [2:0]         port_offset;
	logic [7:0]         write_value;
	logic [6:0]         scan_code;
	logic               extended_key;
	logic               pressed;
	logic signed [15:0] move_dx;
	logic signed [15:0] move_dy;
	logic [1:0]         button_index;

	modport source (output valid, mode, port_offset, write_value, scan_code, extended_key,
		pressed, move_dx, move_dy, button_index, input ready);
	modport sink (input valid, mode, port_offset, write_value, scan_code, extended_key,
		pressed, move_dx, move_dy, button_index, output ready);
endinterface

interface ps2kmc_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       irq_port1;
	logic       irq_port2;
	logic       a20_enable;
	logic       a20_changed;
	logic [2:0] error_code;

	modport source (output valid, read_data, irq_port1, irq_port2, a20_enable, a20_changed,
		error_code, input ready);
	modport sink (input valid, read_data, irq_port1, irq_port2, a20_enable, a20_changed,
		error_code, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ps2kmc_ram.sv =====
// Controller RAM: synchronous memory, registered read, per-byte valid bits.
// Depends on ps2kmc_pkg.
`default_nettype none

module ps2kmc_ram #(
	parameter int RAM_BYTES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ps2kmc_pkg::ram_req_t req,
	output logic [7:0]           rdata
);
	import ps2kmc_pkg::*;

	localparam int AW = $clog2(RAM_BYTES);

	logic [7:0]           mem [RAM_BYTES];
	logic [RAM_BYTES-1:0] vld_q;
	logic [7:0]           rd_s1;
	logic [7:0]           raddr_s1;
	logic                 rd_vld_s1;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[AW-1:0]] <= req.wdata;
		end
		rd_s1    <= mem[req.raddr[AW-1:0]];
		raddr_s1 <= req.raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= vld_q[req.raddr[AW-1:0]];
			if (req.clr) begin
				vld_q <= '0;
			end else if (req.we) begin
				vld_q[req.waddr[AW-1:0]] <= 1'b1;
			end
		end
	end

	assign rdata = rd_vld_s1 ? rd_s1 : ram_init_byte(raddr_s1);

endmodule

`default_nettype wire

// ===== hw/rtl/ps2kmc_fifo.sv =====
// Byte FIFO on a synchronous memory with registered read data.
// Depends on ps2kmc_pkg.
`default_nettype none

module ps2kmc_fifo #(
	parameter int DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ps2kmc_pkg::fifo_req_t req,
	output ps2kmc_pkg::fifo_sts_t sts,
	output logic [7:0]            rdata
);
	import ps2kmc_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [7:0]    mem [DEPTH];
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [7:0]    rdata_q;

	function automatic logic [AW-1:0] ptr_next(logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (req.push) begin
			mem[tail_q] <= req.wdata;
		end
		if (req.pop) begin
			rdata_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (req.clr) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (req.push) begin
				tail_q <= ptr_next(tail_q);
			end
			if (req.pop) begin
				head_q <= ptr_next(head_q);
			end
			case ({req.push, req.pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign sts.empty = (count_q == '0);
	assign sts.full  = (count_q == CW'(DEPTH));
	assign rdata     = rdata_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ps2kmc_top.sv =====
// Steps: DECODE, RAMRD on a RAM read, PUSH writing one FIFO byte a cycle unless it is full
// (up to four per item), FILL, LOAD on a latch refill, then FINISH registers the result.
// Throughput: one item at a time; the next item is taken once the result is registered,
// even while that result waits on the response side.
// Reset: asynchronous, active low; the RAM valid bits clear at once, no clearing pass.
// Depends on ps2kmc_pkg, ps2kmc_if, ps2kmc_ram, ps2kmc_fifo, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ps2_keyboard_mouse_controller_unit #(
	parameter int KEYBOARD_FIFO_DEPTH = 16,
	parameter int MOUSE_FIFO_DEPTH    = 16,
	parameter int RAM_BYTES           = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	ps2kmc_req_if.sink          req,
	ps2kmc_rsp_if.source        rsp
);
	import ps2kmc_pkg::*;

	state_t state_q, state_d;

	logic [2:0]         mode_q;
	logic [2:0]         off_q;
	logic [7:0]         wv_q;
	logic [6:0]         sc_q;
	logic               ext_q;
	logic               prs_q;
	logic signed [15:0] dx_q;
	logic signed [15:0] dy_q;
	logic [1:0]         btn_q;

	logic               cmd_pend_q;
	logic [7:0]         portb_q;
	logic [7:0]         latch_q;
	logic [1:0]         lsrc_q;
	logic [7:0]         tgt_q;
	logic [1:0]         dest_q;
	logic               await_q;
	logic               argkb_q;
	logic [7:0]         pdc_q;
	logic               wrap_q;
	logic               report_q;
	logic               scal_q;
	logic [7:0]         res_q;
	logic [7:0]         rate_q;
	logic [2:0]         btns_q;
	logic signed [15:0] sumx_q;
	logic signed [15:0] sumy_q;
	logic               a20_q;
	logic [7:0]         cfg_q;
	logic [7:0]         base_q;

	logic [7:0] bytes_q [4];
	logic [2:0] nbyte_q;
	logic [1:0] idx_q;
	logic       to_ms_q;
	logic       check_q;
	logic [2:0] err_q;
	logic [2:0] errpost_q;
	logic [7:0] rd_q;
	logic       a20chg_q;
	logic       pop_ms_q;

	logic       rsp_valid_q;
	logic [7:0] rsp_rd_q;
	logic       rsp_irq1_q;
	logic       rsp_irq2_q;
	logic       rsp_a20_q;
	logic       rsp_a20chg_q;
	logic [2:0] rsp_err_q;

	// decode results
	logic               n_cmd_pend;
	logic [7:0]         n_portb;
	logic [7:0]         n_latch;
	logic [1:0]         n_lsrc;
	logic [7:0]         n_tgt;
	logic [1:0]         n_dest;
	logic               n_await;
	logic               n_argkb;
	logic [7:0]         n_pdc;
	logic               n_wrap;
	logic               n_report;
	logic               n_scal;
	logic [7:0]         n_res;
	logic [7:0]         n_rate;
	logic [2:0]         n_btns;
	logic [15:0]        n_sumx;
	logic [15:0]        n_sumy;
	logic               n_a20;
	logic [7:0]         n_cfg;
	logic [7:0]         n_base;
	logic [7:0]         n_bytes [4];
	logic [2:0]         n_nbyte;
	logic               n_to_ms;
	logic               n_check;
	logic               n_ramrd;
	logic [2:0]         n_err;
	logic [2:0]         n_errpost;
	logic [7:0]         n_rd;
	logic               n_a20chg;
	logic               n_fclr;
	logic               n_we;
	logic [7:0]         n_waddr;
	logic [7:0]         n_wdata;

	logic [7:0]         coff;
	logic               coff_bad;
	logic [16:0]        sumx_w;
	logic [16:0]        sumy_w;
	logic signed [16:0] ny;
	logic               xov;
	logic               yov;
	logic [7:0]         xb;
	logic [7:0]         yb;
	logic [7:0]         mstat;

	ram_req_t   ram_req;
	logic [7:0] ram_rdata;
	fifo_req_t  kb_req;
	fifo_req_t  ms_req;
	fifo_sts_t  kb_sts;
	fifo_sts_t  ms_sts;
	logic [7:0] kb_rdata;
	logic [7:0] ms_rdata;

	logic push_full;
	logic push_last;
	logic fill_kb;
	logic fill_ms;
	logic finish_go;

	ps2kmc_ram #(.RAM_BYTES(RAM_BYTES)) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ram_req),
		.rdata  (ram_rdata)
	);

	ps2kmc_fifo #(.DEPTH(KEYBOARD_FIFO_DEPTH)) u_kb_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (kb_req),
		.sts    (kb_sts),
		.rdata  (kb_rdata)
	);

	ps2kmc_fifo #(.DEPTH(MOUSE_FIFO_DEPTH)) u_ms_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ms_req),
		.sts    (ms_sts),
		.rdata  (ms_rdata)
	);

	assign coff = wv_q[5] ? {3'b001, wv_q[4:0]} : base_q + {3'b000, wv_q[4:0]};
	assign coff_bad = ({1'b0, coff} >= 9'(RAM_BYTES));
	assign sumx_w = {sumx_q[15], sumx_q} + {dx_q[15], dx_q};
	assign sumy_w = {sumy_q[15], sumy_q} + {dy_q[15], dy_q};
	assign ny = 17'sd0 - $signed({sumy_q[15], sumy_q});
	assign xov = (sumx_q > 16'sd255) || (sumx_q < -16'sd255);
	assign yov = (ny > 17'sd255) || (ny < -17'sd255);
	assign xb = xov ? (sumx_q[15] ? 8'h01 : 8'hFF) : sumx_q[7:0];
	assign yb = yov ? (ny[16] ? 8'h01 : 8'hFF) : ny[7:0];
	assign mstat = {yov, xov, ny[16], sumx_q[15], 1'b1, btns_q};

	always_comb begin
		n_cmd_pend = cmd_pend_q;
		n_portb    = portb_q;
		n_latch    = latch_q;
		n_lsrc     = lsrc_q;
		n_tgt      = tgt_q;
		n_dest     = dest_q;
		n_await    = await_q;
		n_argkb    = argkb_q;
		n_pdc      = pdc_q;
		n_wrap     = wrap_q;
		n_report   = report_q;
		n_scal     = scal_q;
		n_res      = res_q;
		n_rate     = rate_q;
		n_btns     = btns_q;
		n_sumx     = sumx_q;
		n_sumy     = sumy_q;
		n_a20      = a20_q;
		n_cfg      = cfg_q;
		n_base     = base_q;
		for (int i = 0; i < 4; i++) begin
			n_bytes[i] = BYTE_ZERO;
		end
		n_nbyte   = 3'd0;
		n_to_ms   = 1'b0;
		n_check   = 1'b0;
		n_ramrd   = 1'b0;
		n_err     = ERR_NONE;
		n_errpost = ERR_NONE;
		n_rd      = 8'h00;
		n_a20chg  = 1'b0;
		n_fclr    = 1'b0;
		n_we      = 1'b0;
		n_waddr   = RAM_CFG_ADDR;
		n_wdata   = cfg_q;

		unique case (mode_q)
			MODE_BUS_READ: begin
				unique case (off_q)
					OFF_DATA: begin
						n_rd    = latch_q;
						n_lsrc  = SRC_EMPTY;
						n_check = 1'b1;
					end
					OFF_PORTB: begin
						n_portb = portb_q ^ 8'h10;
						n_rd    = portb_q ^ 8'h10;
					end
					OFF_CMD: begin
						n_rd = {2'b00, lsrc_q == SRC_MOUSE, 1'b0, cmd_pend_q, 2'b00,
							lsrc_q != SRC_EMPTY};
					end
					default: begin
						n_rd  = 8'hFF;
						n_err = ERR_UNSUP;
					end
				endcase
			end
			MODE_BUS_WRITE: begin
				unique case (off_q)
					OFF_DATA: begin
						n_check = 1'b1;
						if (cmd_pend_q) begin
							n_dest     = DEST_KBD;
							n_cmd_pend = 1'b0;
							unique case (dest_q)
								DEST_RAM: begin
									if ({1'b0, tgt_q} < 9'(RAM_BYTES)) begin
										n_we    = 1'b1;
										n_waddr = tgt_q;
										n_wdata = wv_q;
										if (tgt_q == RAM_CFG_ADDR) n_cfg = wv_q;
										if (tgt_q == RAM_BASE_ADDR) n_base = wv_q;
									end
									n_tgt = TARGET_NONE;
								end
								DEST_OUTP: begin
									if (wv_q == A20_OFF || wv_q == A20_ON) begin
										n_a20    = wv_q[1];
										n_a20chg = 1'b1;
									end else begin
										n_err = ERR_UNSUP;
									end
								end
								DEST_MOUSE: begin
									n_cfg   = cfg_q & ~8'h20;
									n_we    = 1'b1;
									n_wdata = cfg_q & ~8'h20;
									n_to_ms = 1'b1;
									n_nbyte = 3'd1;
									n_bytes[0] = BYTE_ACK;
									if (await_q) begin
										if (argkb_q) n_err = ERR_OVERLAP;
										n_await = 1'b0;
										if (pdc_q == MS_CMD_SET_RES) n_res = wv_q;
										else if (pdc_q == MS_CMD_RATE) n_rate = wv_q;
									end else if (wrap_q && wv_q != MS_CMD_END_WRAP &&
										wv_q != MS_CMD_RESET) begin
										n_bytes[0] = wv_q;
									end else begin
										unique case (wv_q) inside
											MS_CMD_SCALE1: n_scal = 1'b0;
											MS_CMD_SCALE2: n_scal = 1'b1;
											MS_CMD_SET_RES, MS_CMD_RATE: begin
												n_pdc   = wv_q;
												n_await = 1'b1;
												n_argkb = 1'b0;
											end
											MS_CMD_STATUS: begin
												n_nbyte    = 3'd4;
												n_bytes[1] = {2'b00, report_q, scal_q, 1'b0,
													btns_q};
												n_bytes[2] = res_q;
												n_bytes[3] = rate_q;
												n_sumx     = 16'h0000;
												n_sumy     = 16'h0000;
											end
											MS_CMD_END_WRAP: n_wrap = 1'b0;
											MS_CMD_WRAP:     n_wrap = 1'b1;
											MS_CMD_ID: begin
												n_nbyte    = 3'd2;
												n_bytes[1] = BYTE_ZERO;
											end
											MS_CMD_ENABLE:  n_report = 1'b1;
											MS_CMD_DISABLE: n_report = 1'b0;
											MS_CMD_RESET: begin
												n_wrap     = 1'b0;
												n_rate     = RATE_RESET;
												n_res      = RES_RESET;
												n_scal     = 1'b0;
												n_report   = 1'b0;
												n_btns     = 3'd0;
												n_sumx     = 16'h0000;
												n_sumy     = 16'h0000;
												n_nbyte    = 3'd3;
												n_bytes[1] = BYTE_BAT_OK;
												n_bytes[2] = BYTE_ZERO;
											end
											default: n_errpost = ERR_DEVCMD;
										endcase
									end
								end
								default: n_err = ERR_UNSUP;
							endcase
						end else begin
							n_cfg   = cfg_q & ~8'h10;
							n_we    = 1'b1;
							n_wdata = cfg_q & ~8'h10;
							n_nbyte = 3'd1;
							n_bytes[0] = BYTE_ACK;
							if (await_q) begin
								if (!argkb_q) n_err = ERR_OVERLAP;
								n_await = 1'b0;
							end else begin
								unique case (wv_q) inside
									KB_CMD_MISC, KB_CMD_ID, KB_CMD_ENABLE, KB_CMD_DISABLE: begin
									end
									KB_CMD_LEDS, KB_CMD_RATE: begin
										n_pdc   = wv_q;
										n_await = 1'b1;
										n_argkb = 1'b1;
									end
									KB_CMD_RESET: begin
										n_nbyte    = 3'd2;
										n_bytes[1] = BYTE_BAT_OK;
									end
									default: n_errpost = ERR_DEVCMD;
								endcase
							end
						end
					end
					OFF_CMD: begin
						if (!wv_q[7]) begin
							if (coff_bad) begin
								n_err = ERR_RANGE;
							end else if (wv_q[6]) begin
								n_tgt      = coff;
								n_dest     = DEST_RAM;
								n_cmd_pend = 1'b1;
							end else begin
								n_ramrd = 1'b1;
								n_nbyte = 3'd1;
								n_check = 1'b1;
							end
						end else begin
							n_check = 1'b1;
							unique case (wv_q) inside
								CMD_MS_DISABLE: begin
									n_cfg = cfg_q | 8'h20;
									n_we  = 1'b1;
									n_wdata = cfg_q | 8'h20;
								end
								CMD_MS_ENABLE: begin
									n_cfg = cfg_q & ~8'h20;
									n_we  = 1'b1;
									n_wdata = cfg_q & ~8'h20;
								end
								CMD_KBD_DISABLE: begin
									n_cfg = cfg_q | 8'h10;
									n_we  = 1'b1;
									n_wdata = cfg_q | 8'h10;
								end
								CMD_KBD_ENABLE: begin
									n_cfg = cfg_q & ~8'h10;
									n_we  = 1'b1;
									n_wdata = cfg_q & ~8'h10;
								end
								CMD_MS_TEST, CMD_KBD_TEST: begin
									n_nbyte    = 3'd1;
									n_bytes[0] = BYTE_ZERO;
								end
								CMD_SELF_TEST: begin
									n_cmd_pend = 1'b0;
									n_portb    = 8'h00;
									n_latch    = 8'h00;
									n_lsrc     = SRC_EMPTY;
									n_tgt      = TARGET_NONE;
									n_dest     = DEST_KBD;
									n_await    = 1'b0;
									n_argkb    = 1'b1;
									n_pdc      = 8'h00;
									n_wrap     = 1'b0;
									n_report   = 1'b0;
									n_scal     = 1'b0;
									n_res      = RES_RESET;
									n_rate     = RATE_RESET;
									n_btns     = 3'd0;
									n_sumx     = 16'h0000;
									n_sumy     = 16'h0000;
									n_a20      = 1'b0;
									n_cfg      = CFG_RESET;
									n_base     = BASE_RESET;
									n_a20chg   = 1'b1;
									n_fclr     = 1'b1;
									n_nbyte    = 3'd1;
									n_bytes[0] = BYTE_TEST_OK;
								end
								CMD_WR_OUTPORT: begin
									n_dest     = DEST_OUTP;
									n_cmd_pend = 1'b1;
								end
								CMD_WR_MOUSE: begin
									n_dest     = DEST_MOUSE;
									n_cmd_pend = 1'b1;
								end
								CMD_NOP: begin
								end
								default: begin
									n_check = 1'b0;
									n_err   = ERR_UNSUP;
								end
							endcase
						end
					end
					OFF_PORTB: begin
					end
					default: n_err = ERR_UNSUP;
				endcase
			end
			MODE_KEY: begin
				n_check = 1'b1;
				if (ext_q) begin
					n_nbyte    = 3'd2;
					n_bytes[0] = BYTE_EXT;
					n_bytes[1] = {~prs_q, sc_q};
				end else begin
					n_nbyte    = 3'd1;
					n_bytes[0] = {~prs_q, sc_q};
				end
			end
			MODE_MOVE: begin
				n_sumx = sat16(sumx_w);
				n_sumy = sat16(sumy_w);
			end
			MODE_BUTTON: begin
				if (btn_q != 2'd3) begin
					n_btns[btn_q] = prs_q;
				end
			end
			MODE_REPORT: begin
				if (!cfg_q[CFG_MS_DIS] && report_q) begin
					n_check    = 1'b1;
					n_to_ms    = 1'b1;
					n_nbyte    = 3'd3;
					n_bytes[0] = mstat;
					n_bytes[1] = xb;
					n_bytes[2] = yb;
					n_sumx     = 16'h0000;
					n_sumy     = 16'h0000;
				end
			end
			default: n_err = ERR_UNSUP;
		endcase
	end

	assign push_full = to_ms_q ? ms_sts.full : kb_sts.full;
	assign push_last = ({1'b0, idx_q} == nbyte_q - 3'd1);
	assign fill_kb   = (state_q == ST_FILL) && check_q && (lsrc_q == SRC_EMPTY) && !kb_sts.empty;
	assign fill_ms   = (state_q == ST_FILL) && check_q && (lsrc_q == SRC_EMPTY) && kb_sts.empty &&
		!ms_sts.empty;
	assign finish_go = (state_q == ST_FINISH) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		ram_req.we    = (state_q == ST_DECODE) && n_we;
		ram_req.clr   = (state_q == ST_DECODE) && n_fclr;
		ram_req.waddr = n_waddr;
		ram_req.wdata = n_wdata;
		ram_req.raddr = coff;

		kb_req.push  = (state_q == ST_PUSH) && !to_ms_q && !kb_sts.full;
		kb_req.pop   = fill_kb;
		kb_req.clr   = (state_q == ST_DECODE) && n_fclr;
		kb_req.wdata = bytes_q[idx_q];

		ms_req.push  = (state_q == ST_PUSH) && to_ms_q && !ms_sts.full;
		ms_req.pop   = fill_ms;
		ms_req.clr   = (state_q == ST_DECODE) && n_fclr;
		ms_req.wdata = bytes_q[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (n_nbyte == 3'd0) state_d = ST_FILL;
				else if (n_ramrd) state_d = ST_RAMRD;
				else state_d = ST_PUSH;
			end
			ST_RAMRD: state_d = ST_PUSH;
			ST_PUSH: begin
				if (push_last) state_d = ST_FILL;
			end
			ST_FILL: begin
				if (fill_kb || fill_ms) state_d = ST_LOAD;
				else state_d = ST_FINISH;
			end
			ST_LOAD: state_d = ST_FINISH;
			ST_FINISH: begin
				if (finish_go) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_q <= req.mode;
			off_q  <= req.port_offset;
			wv_q   <= req.write_value;
			sc_q   <= req.scan_code;
			ext_q  <= req.extended_key;
			prs_q  <= req.pressed;
			dx_q   <= req.move_dx;
			dy_q   <= req.move_dy;
			btn_q  <= req.button_index;
		end
		if (state_q == ST_DECODE) begin
			bytes_q   <= n_bytes;
			nbyte_q   <= n_nbyte;
			to_ms_q   <= n_to_ms;
			errpost_q <= n_errpost;
			rd_q      <= n_rd;
		end
		if (state_q == ST_RAMRD) begin
			bytes_q[0] <= ram_rdata;
		end
		if (fill_kb || fill_ms) begin
			pop_ms_q <= fill_ms;
		end
		if (finish_go) begin
			rsp_rd_q     <= rd_q;
			rsp_irq1_q   <= check_q && (lsrc_q == SRC_KBD) && cfg_q[CFG_KBD_IRQ] &&
				!cfg_q[CFG_KBD_DIS];
			rsp_irq2_q   <= check_q && (lsrc_q == SRC_MOUSE) && cfg_q[CFG_MS_IRQ] &&
				!cfg_q[CFG_MS_DIS];
			rsp_a20_q    <= a20_q;
			rsp_a20chg_q <= a20chg_q;
			rsp_err_q    <= (err_q != ERR_NONE) ? err_q : errpost_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_pend_q  <= 1'b0;
			portb_q     <= 8'h00;
			latch_q     <= 8'h00;
			lsrc_q      <= SRC_EMPTY;
			tgt_q       <= TARGET_NONE;
			dest_q      <= DEST_KBD;
			await_q     <= 1'b0;
			argkb_q     <= 1'b1;
			pdc_q       <= 8'h00;
			wrap_q      <= 1'b0;
			report_q    <= 1'b0;
			scal_q      <= 1'b0;
			res_q       <= RES_RESET;
			rate_q      <= RATE_RESET;
			btns_q      <= 3'd0;
			sumx_q      <= 16'sd0;
			sumy_q      <= 16'sd0;
			a20_q       <= 1'b0;
			cfg_q       <= CFG_RESET;
			base_q      <= BASE_RESET;
			idx_q       <= 2'd0;
			check_q     <= 1'b0;
			err_q       <= ERR_NONE;
			a20chg_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_DECODE: begin
					cmd_pend_q <= n_cmd_pend;
					portb_q    <= n_portb;
					latch_q    <= n_latch;
					lsrc_q     <= n_lsrc;
					tgt_q      <= n_tgt;
					dest_q     <= n_dest;
					await_q    <= n_await;
					argkb_q    <= n_argkb;
					pdc_q      <= n_pdc;
					wrap_q     <= n_wrap;
					report_q   <= n_report;
					scal_q     <= n_scal;
					res_q      <= n_res;
					rate_q     <= n_rate;
					btns_q     <= n_btns;
					sumx_q     <= n_sumx;
					sumy_q     <= n_sumy;
					a20_q      <= n_a20;
					cfg_q      <= n_cfg;
					base_q     <= n_base;
					idx_q      <= 2'd0;
					check_q    <= n_check;
					err_q      <= n_err;
					a20chg_q   <= n_a20chg;
				end
				ST_PUSH: begin
					idx_q <= idx_q + 2'd1;
					if (push_full && err_q == ERR_NONE) err_q <= ERR_FIFO;
				end
				ST_FILL: begin
					if (fill_kb) lsrc_q <= SRC_KBD;
					else if (fill_ms) lsrc_q <= SRC_MOUSE;
				end
				ST_LOAD: begin
					latch_q <= pop_ms_q ? ms_rdata : kb_rdata;
				end
				default: begin
				end
			endcase
			if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
			if (finish_go) rsp_valid_q <= 1'b1;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.read_data   = rsp_rd_q;
	assign rsp.irq_port1   = rsp_irq1_q;
	assign rsp.irq_port2   = rsp_irq2_q;
	assign rsp.a20_enable  = rsp_a20_q;
	assign rsp.a20_changed = rsp_a20chg_q;
	assign rsp.error_code  = rsp_err_q;

	`PS2KMC_ASSERT(a_empty_latch_empty_fifos, (state_q == ST_IDLE && lsrc_q == SRC_EMPTY) |-> (kb_sts.empty && ms_sts.empty), "latch empty while a FIFO holds bytes")
	`PS2KMC_ASSERT(a_load_after_fill, (state_q == ST_LOAD) |-> $past(state_q == ST_FILL), "latch load without a FIFO pop")
	`PS2KMC_NEVER(a_no_push_full, (kb_req.push && kb_sts.full) || (ms_req.push && ms_sts.full), "push into a full FIFO")
	`PS2KMC_ASSERT(a_ram_wr_range, ram_req.we |-> ({1'b0, ram_req.waddr} < 9'(RAM_BYTES)), "RAM write beyond the RAM")

endmodule

`default_nettype wire
